>>> src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_W     = 12;
    localparam int NUM_LEVELS = 11;
    localparam int LVL_W      = 4;
    localparam int CNT_W      = 13;
    localparam int FRAME_W    = 20;
    localparam int ABS_W      = 21;
    localparam int SIZE_W     = 12;
    localparam int ADDR_W     = 3;

    localparam logic [LVL_W-1:0] LVL_ALLOC = LVL_W'(NUM_LEVELS);
    localparam logic [LVL_W-1:0] LVL_TOP   = LVL_W'(NUM_LEVELS - 1);

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OOM      = 2'd1;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd2;
    localparam logic [1:0] STAT_BAD_FREE = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_FIRST_FRAME = 1'b0;
    localparam logic REG_PAGES       = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0] first_frame;
        logic [CNT_W-1:0]   pages_in_use;
    } cfg_t;

endpackage

>>> src/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/bpa_cfg.sv
// ----------------------------------------------------------------------------
// bpa_cfg
// APB register file: segment start frame and segment length.
// ----------------------------------------------------------------------------
module bpa_cfg
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [FRAME_W-1:0] first_frame_reg;
    logic [CNT_W-1:0]   pages_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_frame_reg <= '0;
            pages_reg       <= CNT_W'(NUM_PAGES);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_FIRST_FRAME: first_frame_reg <= pwdata[FRAME_W-1:0];
                REG_PAGES:       pages_reg       <= pwdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIRST_FRAME: prdata = {{(32-FRAME_W){1'b0}}, first_frame_reg};
            REG_PAGES:       prdata = {{(32-CNT_W){1'b0}}, pages_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.first_frame  = first_frame_reg;
    assign cfg.pages_in_use = pages_reg;

endmodule

>>> src/bpa_seq.sv
// ----------------------------------------------------------------------------
// bpa_seq
// Allocator sequencer: free-list search, split, merge and list updates over
// the level and link memories.
// ----------------------------------------------------------------------------
module bpa_seq
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [1:0]        m_tuser
);

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_DECODE  = 13'b0000000000100,
        S_FREE_CK = 13'b0000000001000,
        S_LNK_RD  = 13'b0000000010000,
        S_UNLINK  = 13'b0000000100000,
        S_SPLIT   = 13'b0000001000000,
        S_PUSH_A  = 13'b0000010000000,
        S_PUSH_B  = 13'b0000100000000,
        S_MRG_RD  = 13'b0001000000000,
        S_MRG_CMP = 13'b0010000000000,
        S_MRG_END = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [PAGE_W-1:0] clr_reg, clr_next;
    logic              op_reg, op_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  cur_reg, cur_next;
    logic [PAGE_W-1:0] pg_reg, pg_next;
    logic [CNT_W-1:0]  tgt_reg, tgt_next;
    logic [ABS_W-1:0]  abs_reg, abs_next;
    logic [1:0]        stat_reg, stat_next;
    logic [PAGE_W-1:0] res_reg, res_next;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [PAGE_W-1:0] head_reg [NUM_LEVELS];
    logic [PAGE_W-1:0] head_next [NUM_LEVELS];
    logic [CNT_W-1:0]  cnt_reg [NUM_LEVELS];
    logic [CNT_W-1:0]  cnt_next [NUM_LEVELS];
    logic              mval_reg, mval_next;
    logic [1:0]        mstat_reg, mstat_next;
    logic [PAGE_W-1:0] mpage_reg, mpage_next;
    logic [CNT_W-1:0]  mfree_reg, mfree_next;

    // memory ports
    logic              lv_we, nx_we, pv_we;
    logic [PAGE_W-1:0] lv_waddr, nx_waddr, pv_waddr;
    logic [LVL_W-1:0]  lv_wdata, lv_rdata;
    logic [PAGE_W-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
    logic [PAGE_W-1:0] lv_raddr, lk_raddr;

    bpa_ram #(.WIDTH(LVL_W), .DEPTH(NUM_PAGES)) u_level (
        .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
        .raddr(lv_raddr), .rdata(lv_rdata)
    );
    bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(lk_raddr), .rdata(nx_rdata)
    );
    bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(lk_raddr), .rdata(pv_rdata)
    );

    logic [CNT_W-1:0]  seg_end;
    logic [CNT_W-1:0]  blk;
    logic [LVL_W-1:0]  req_lvl;
    logic              bad_size;
    logic [LVL_W-1:0]  found_lvl;
    logic              found;
    logic [LVL_W-1:0]  cur_inc;
    logic [ABS_W-1:0]  b_abs;
    logic [ABS_W-1:0]  b_rel;
    logic              last;
    logic              head_hit;
    logic              free_bad;

    assign seg_end = (cfg.pages_in_use < CNT_W'(NUM_PAGES)) ? cfg.pages_in_use
                                                            : CNT_W'(NUM_PAGES);
    assign blk     = CNT_W'(1) << lvl_reg;
    assign cur_inc = cur_reg + LVL_W'(1);
    assign b_abs   = abs_reg ^ (ABS_W'(1) << cur_reg);
    assign b_rel   = b_abs - ABS_W'(cfg.first_frame);
    assign last     = (nx_rdata == tgt_reg[PAGE_W-1:0]);
    assign head_hit = (head_reg[cur_reg] == tgt_reg[PAGE_W-1:0]);

    always_comb
    begin
        req_lvl = LVL_TOP;
        for (int k = NUM_LEVELS - 1; k >= 0; k--)
        begin
            if ({1'b0, size_reg} <= (CNT_W'(1) << k))
            begin
                req_lvl = LVL_W'(k);
            end
        end
        bad_size = (size_reg == '0) || ({1'b0, size_reg} > (CNT_W'(1) << LVL_TOP));
    end

    // lowest non-empty list at or above the request level
    always_comb
    begin
        found     = 1'b0;
        found_lvl = '0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--)
        begin
            if ((LVL_W'(k) >= req_lvl) && (cnt_reg[k] != '0))
            begin
                found     = 1'b1;
                found_lvl = LVL_W'(k);
            end
        end
    end

    assign free_bad = ({1'b0, page_reg} >= seg_end)
                   || (({1'b0, page_reg} + blk) > seg_end)
                   || ((abs_reg & ABS_W'(blk - CNT_W'(1))) != '0)
                   || (lv_rdata != LVL_ALLOC);

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        op_next       = op_reg;
        size_next     = size_reg;
        page_next     = page_reg;
        lvl_next      = lvl_reg;
        cur_next      = cur_reg;
        pg_next       = pg_reg;
        tgt_next      = tgt_reg;
        abs_next      = abs_reg;
        stat_next     = stat_reg;
        res_next      = res_reg;
        free_cnt_next = free_cnt_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        mval_next     = mval_reg;
        mstat_next    = mstat_reg;
        mpage_next    = mpage_reg;
        mfree_next    = mfree_reg;

        lv_we    = 1'b0;
        lv_waddr = tgt_reg[PAGE_W-1:0];
        lv_wdata = LVL_ALLOC;
        nx_we    = 1'b0;
        nx_waddr = tgt_reg[PAGE_W-1:0];
        nx_wdata = tgt_reg[PAGE_W-1:0];
        pv_we    = 1'b0;
        pv_waddr = tgt_reg[PAGE_W-1:0];
        pv_wdata = tgt_reg[PAGE_W-1:0];
        lv_raddr = b_rel[PAGE_W-1:0];
        lk_raddr = tgt_reg[PAGE_W-1:0];

        s_tready = (state_reg == S_IDLE);

        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                lv_we    = 1'b1;
                lv_waddr = clr_reg;
                clr_next = clr_reg + PAGE_W'(1);
                if (clr_reg == PAGE_W'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    size_next  = s_tdata[11:0];
                    page_next  = s_tdata[23:12];
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                lvl_next = req_lvl;
                lv_raddr = page_reg;
                abs_next = ABS_W'(cfg.first_frame) + ABS_W'(page_reg);
                res_next = '0;
                if (bad_size)
                begin
                    stat_next  = STAT_BAD_SIZE;
                    state_next = S_DONE;
                end
                else if (op_reg == CMD_FREE)
                begin
                    state_next = S_FREE_CK;
                end
                else if (!found)
                begin
                    stat_next  = STAT_OOM;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = found_lvl;
                    pg_next    = head_reg[found_lvl];
                    tgt_next   = {1'b0, head_reg[found_lvl]};
                    state_next = S_LNK_RD;
                end
            end

            S_FREE_CK:
            begin
                if (free_bad)
                begin
                    stat_next  = STAT_BAD_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = lvl_reg;
                    state_next = S_MRG_RD;
                end
            end

            S_LNK_RD:
            begin
                state_next = S_UNLINK;
            end

            S_UNLINK:
            begin
                lv_we = 1'b1;
                if (head_hit)
                begin
                    if (!last)
                    begin
                        head_next[cur_reg] = nx_rdata;
                        pv_we    = 1'b1;
                        pv_waddr = nx_rdata;
                        pv_wdata = nx_rdata;
                    end
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata;
                    nx_wdata = last ? pv_rdata : nx_rdata;
                    if (!last)
                    begin
                        pv_we    = 1'b1;
                        pv_waddr = nx_rdata;
                        pv_wdata = pv_rdata;
                    end
                end
                cnt_next[cur_reg] = cnt_reg[cur_reg] - CNT_W'(1);
                if (op_reg == CMD_ALLOC)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    cur_next   = cur_inc;
                    abs_next   = abs_reg & ({ABS_W{1'b1}} << cur_inc);
                    state_next = S_MRG_RD;
                end
            end

            S_SPLIT:
            begin
                if (cur_reg > lvl_reg)
                begin
                    cur_next   = cur_reg - LVL_W'(1);
                    tgt_next   = {1'b0, pg_reg} + (CNT_W'(1) << (cur_reg - LVL_W'(1)));
                    state_next = S_PUSH_A;
                end
                else
                begin
                    free_cnt_next = free_cnt_reg - blk;
                    res_next      = pg_reg;
                    stat_next     = STAT_OK;
                    state_next    = S_DONE;
                end
            end

            S_PUSH_A:
            begin
                if (tgt_reg[PAGE_W] == 1'b0)
                begin
                    nx_we    = 1'b1;
                    nx_wdata = (cnt_reg[cur_reg] == '0) ? tgt_reg[PAGE_W-1:0]
                                                        : head_reg[cur_reg];
                    pv_we    = 1'b1;
                    lv_we    = 1'b1;
                    lv_wdata = cur_reg;
                    if (cnt_reg[cur_reg] != '0)
                    begin
                        state_next = S_PUSH_B;
                    end
                    else
                    begin
                        head_next[cur_reg] = tgt_reg[PAGE_W-1:0];
                        cnt_next[cur_reg]  = cnt_reg[cur_reg] + CNT_W'(1);
                        state_next         = (op_reg == CMD_ALLOC) ? S_SPLIT : S_MRG_END;
                    end
                end
                else
                begin
                    // block lies past the page array: drop it
                    state_next = (op_reg == CMD_ALLOC) ? S_SPLIT : S_MRG_END;
                end
            end

            S_PUSH_B:
            begin
                pv_we              = 1'b1;
                pv_waddr           = head_reg[cur_reg];
                head_next[cur_reg] = tgt_reg[PAGE_W-1:0];
                cnt_next[cur_reg]  = cnt_reg[cur_reg] + CNT_W'(1);
                state_next         = (op_reg == CMD_ALLOC) ? S_SPLIT : S_MRG_END;
            end

            S_MRG_RD:
            begin
                if ((cur_reg >= LVL_TOP) || (b_abs < ABS_W'(cfg.first_frame))
                    || (b_rel >= ABS_W'(seg_end)))
                begin
                    tgt_next   = CNT_W'(abs_reg - ABS_W'(cfg.first_frame));
                    state_next = S_PUSH_A;
                end
                else
                begin
                    tgt_next   = CNT_W'(b_rel);
                    state_next = S_MRG_CMP;
                end
            end

            S_MRG_CMP:
            begin
                if (lv_rdata == cur_reg)
                begin
                    state_next = S_LNK_RD;
                end
                else
                begin
                    tgt_next   = CNT_W'(abs_reg - ABS_W'(cfg.first_frame));
                    state_next = S_PUSH_A;
                end
            end

            S_MRG_END:
            begin
                free_cnt_next = free_cnt_reg + blk;
                res_next      = tgt_reg[PAGE_W-1:0];
                stat_next     = STAT_OK;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!mval_reg || m_tready)
                begin
                    mval_next  = 1'b1;
                    mstat_next = stat_reg;
                    mpage_next = res_reg;
                    mfree_next = free_cnt_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            free_cnt_reg <= '0;
            mval_reg     <= 1'b0;
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            free_cnt_reg <= free_cnt_next;
            mval_reg     <= mval_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        size_reg  <= size_next;
        page_reg  <= page_next;
        lvl_reg   <= lvl_next;
        cur_reg   <= cur_next;
        pg_reg    <= pg_next;
        tgt_reg   <= tgt_next;
        abs_reg   <= abs_next;
        stat_reg  <= stat_next;
        res_reg   <= res_next;
        head_reg  <= head_next;
        mstat_reg <= mstat_next;
        mpage_reg <= mpage_next;
        mfree_reg <= mfree_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tuser  = mstat_reg;
    assign m_tdata  = {{(32-CNT_W-PAGE_W){1'b0}}, mfree_reg, mpage_reg};

endmodule

>>> src/buddy_page_allocator.sv
// Allocate unlinks the found block and splits it down to the request level;
// free checks the block, then merges it with its free buddy level by level.
// Throughput: one request at a time; the sequencer steps through the level and
// link memories. A result waits in the output register.
// Reset: all pages allocated, no free pages; a clearing pass of the
// level memory follows reset, with s_tready low (APB writes are taken).
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy page allocator over one segment of up to 4096 pages.
// ----------------------------------------------------------------------------
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // size_pages[11:0], page_index[23:12]
    input  logic              s_tuser,   // cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // block_page[11:0], free_pages[24:12]
    output logic [1:0]        m_tuser,   // status
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t cfg;

    bpa_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    bpa_seq u_seq (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule

>>> src/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the buddy page allocator.
// ----------------------------------------------------------------------------
module bpa_checker
    import bpa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // failed requests report page zero
    a_fail_page: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tdata[11:0] == '0)
        else $error("nonzero page on failed request");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:25] == '0)
        else $error("padding bits set");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
